[design/sparse_vector_merge_add_assert.svh]
// Assertion macros for the sparse vector merge-add block.
// Expects clk and rst in the scope of each use.
`ifndef SPARSE_VECTOR_MERGE_ADD_ASSERT_SVH
`define SPARSE_VECTOR_MERGE_ADD_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SVMA_CHECK(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SVMA_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/svma_pkg.sv]
// Shared types and codes for the sparse vector merge-add block.
// No dependencies.
package svma_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_APPEND_A = 2'd0;
  localparam logic [1:0] REQ_APPEND_B = 2'd1;
  localparam logic [1:0] REQ_MERGE    = 2'd2;

  // Source codes on the output channel
  localparam logic [1:0] SRC_A   = 2'd0;
  localparam logic [1:0] SRC_B   = 2'd1;
  localparam logic [1:0] SRC_SUM = 2'd2;

  // Command queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    logic [15:0]        pos;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    cmd_kind_t kind;
    entry_t    entry;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_EMPTY
  } eng_state_t;

  typedef struct packed {
    logic merging;
    logic take;
  } eng_status_t;

endpackage

[design/svma_front.sv]
// Front end: accepts input words, classifies the request code and queues commands.
// Depends on svma_pkg.
module svma_front import svma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [15:0]        in_pos,
  input  logic signed [31:0] in_value,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_take
);

  cmd_t             q [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   fill;
  logic             known;
  cmd_kind_t        kind;
  logic             push;
  logic             pop;

  always_comb begin
    known = 1'b1;
    kind  = CMD_MERGE;
    unique case (req_type)
      REQ_APPEND_A: kind = CMD_APPEND_A;
      REQ_APPEND_B: kind = CMD_APPEND_B;
      REQ_MERGE:    kind = CMD_MERGE;
      default:      known = 1'b0;  // unused code: accept and drop
    endcase
  end

  assign in_stall  = (fill == QCW'(QDEPTH));
  assign push      = in_valid && !in_stall && known;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, entry: '{pos: in_pos, value: in_value}};
    end
  end

  // Pointers wrap naturally since the queue depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + QCW'(push) - QCW'(pop);
    end
  end

endmodule

[design/svma_engine.sv]
// Back end: list stores, append handling and the two-pointer merge walk.
// Depends on svma_pkg.
module svma_engine import svma_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_take,
  output eng_status_t        status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pos,
  output logic signed [31:0] out_value,
  output logic [1:0]         source,
  output logic               is_empty,
  output logic               overflowed,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t             mem_a [DEPTH];
  entry_t             mem_b [DEPTH];
  entry_t             rd_a;
  entry_t             rd_b;
  logic [CW-1:0]      count_a;
  logic [CW-1:0]      count_b;
  logic [CW-1:0]      ia;
  logic [CW-1:0]      ib;
  logic               ovf_flag;
  logic               ovf_snap;
  eng_state_t         state;
  eng_state_t         state_next;

  logic               take;
  logic               wr_a;
  logic               wr_b;
  logic               out_free;
  logic               load_out;
  logic               a_more;
  logic               b_more;
  logic               step_a;
  logic               step_b;
  logic [CW-1:0]      ia_adv;
  logic [CW-1:0]      ib_adv;
  logic               emit_last;
  logic [15:0]        emit_pos;
  logic signed [31:0] emit_value;
  logic [1:0]         emit_src;

  assign cmd_take = (state == ST_IDLE);
  assign take     = cmd_valid && cmd_take;
  assign out_free = !out_valid || !out_stall;
  assign wr_a     = take && (cmd.kind == CMD_APPEND_A) && (count_a != CW'(DEPTH));
  assign wr_b     = take && (cmd.kind == CMD_APPEND_B) && (count_b != CW'(DEPTH));

  assign status.merging = (state != ST_IDLE);
  assign status.take    = take;

  // List stores: one write, one registered read per cycle each
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[count_a[AW-1:0]] <= cmd.entry;
    if (wr_b) mem_b[count_b[AW-1:0]] <= cmd.entry;
    rd_a <= mem_a[ia[AW-1:0]];
    rd_b <= mem_b[ib[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && cmd.kind == CMD_MERGE) begin
          state_next = (count_a == '0 && count_b == '0) ? ST_EMPTY : ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = emit_last ? ST_IDLE : ST_FETCH;
      end
      ST_EMPTY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pick the next merged element from the two fronts
  always_comb begin
    a_more     = (ia < count_a);
    b_more     = (ib < count_b);
    step_a     = 1'b0;
    step_b     = 1'b0;
    emit_pos   = rd_b.pos;
    emit_value = rd_b.value;
    emit_src   = SRC_B;
    priority if (a_more && b_more && rd_a.pos == rd_b.pos) begin
      step_a     = 1'b1;
      step_b     = 1'b1;
      emit_pos   = rd_a.pos;
      emit_value = rd_a.value + rd_b.value;
      emit_src   = SRC_SUM;
    end else if (a_more && (!b_more || rd_a.pos < rd_b.pos)) begin
      step_a     = 1'b1;
      emit_pos   = rd_a.pos;
      emit_value = rd_a.value;
      emit_src   = SRC_A;
    end else begin
      step_b = 1'b1;
    end
    ia_adv    = ia + CW'(step_a);
    ib_adv    = ib + CW'(step_b);
    emit_last = (ia_adv >= count_a) && (ib_adv >= count_b);
    load_out  = out_free && (state == ST_EMIT || state == ST_EMPTY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      ia        <= '0;
      ib        <= '0;
      ovf_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (wr_a) count_a <= count_a + CW'(1);
      if (wr_b) count_b <= count_b + CW'(1);
      if (take && cmd.kind != CMD_MERGE && !wr_a && !wr_b) ovf_flag <= 1'b1;

      if (take && cmd.kind == CMD_MERGE) begin
        ia <= '0;
        ib <= '0;
      end
      if (state == ST_EMIT && out_free) begin
        ia <= ia_adv;
        ib <= ib_adv;
      end
      if (load_out && (state == ST_EMPTY || emit_last)) begin
        count_a  <= '0;
        count_b  <= '0;
        ovf_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == CMD_MERGE) ovf_snap <= ovf_flag;
    if (load_out) begin
      overflowed <= ovf_snap;
      if (state == ST_EMPTY) begin
        out_pos   <= '0;
        out_value <= '0;
        source    <= SRC_A;
        is_empty  <= 1'b1;
        last      <= 1'b1;
      end else begin
        out_pos   <= emit_pos;
        out_value <= emit_value;
        source    <= emit_src;
        is_empty  <= 1'b0;
        last      <= emit_last;
      end
    end
  end

endmodule

[design/sparse_vector_merge_add.sv]
// Sparse vector merge-add: two position/value lists merged into one sorted sum.
// Channels: input words (req_type, in_pos, in_value) with in_valid/in_stall;
// result words (out_pos, out_value, source, is_empty, overflowed, last) with
// out_valid/out_stall. A word moves on a clock edge with valid high, stall low.
// Append words (A or B) are stored by the idle back end; an append to a
// full list is dropped and raises the sticky overflow flag. Code 3 is dropped.
// A merge word emits one result word per merged element. Each element passes
// FETCH, where the registered list-store read is made, then EMIT, where the
// compare and add feed the output register. The final word carries last;
// two empty lists give one is_empty word. After the merge both list counts
// and the overflow flag are cleared.
// A two-entry command queue sits between front and back, so appends keep
// flowing while a merge is busy until the queue fills.
// The output register holds its word while out_stall is high; the merge pauses.
// Reset (rst, synchronous) empties the queue, both lists and the flag; list
// contents themselves are not cleared, only their counts.
`include "sparse_vector_merge_add_assert.svh"

module sparse_vector_merge_add import svma_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [15:0]        in_pos,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pos,
  output logic signed [31:0] out_value,
  output logic [1:0]         source,
  output logic               is_empty,
  output logic               overflowed,
  output logic               last
);

  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_take;
  eng_status_t st;

  // Accept and classify words, hold them in the command queue
  svma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .in_pos    (in_pos),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Carry out appends and merges, drive the output register
  svma_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .status     (st),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pos    (out_pos),
    .out_value  (out_value),
    .source     (source),
    .is_empty   (is_empty),
    .overflowed (overflowed),
    .last       (last)
  );

  // A pending word that is not the last one means the merge is still running
  `SVMA_CHECK(a_nonlast_merging, out_valid && !last, st.merging, "non-last word without merge")
  // An empty-merge word is the whole merge result and carries zeros
  `SVMA_CHECK(a_empty_shape, out_valid && is_empty, last && source == SRC_A && out_pos == 16'd0 && out_value == 32'sd0, "malformed empty word")
  // A merge starts only once the previous merge has emitted its last word
  `SVMA_CHECK(a_merge_start, $rose(st.merging), !out_valid || last, "merge overlaps previous")
  // The back end pulls a command only between merges
  `SVMA_CHECK(a_take_idle, st.take, !st.merging, "command taken mid-merge")

endmodule
